/* sv/sse_pkg.sv */
// Package for the sample statistics engine core.
// Status codes and request codes shared by the core and its testbench; no dependencies.
package sse_pkg;
	localparam logic [1:0] REQ_ADD     = 2'd0;
	localparam logic [1:0] REQ_REMOVE  = 2'd1;
	localparam logic [1:0] REQ_REPORT  = 2'd2;
	localparam logic [1:0] REQ_IGNORED = 2'd3;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;
	localparam logic [1:0] ST_TOO_FEW   = 2'd3;
endpackage

/* sv/sample_statistics_engine_core.sv */
// Sample statistics engine core: sorted sample store, running sums and a report sequencer.
// Depends on sse_pkg (request and status codes).
//
// One item is taken when start is high and busy is low; busy stays high while the item
// runs, and the result shows for one cycle with done high in the first cycle busy is low
// again (the receiver cannot stall it). The store is kept in ascending order in a
// single-port-write, registered-read memory. An add to a full or empty store, a remove
// from an empty store, a report with fewer than two samples and the unused request code
// finish in the dispatch state. Otherwise an add walks down from the top entry, moving
// each entry above the new sample up one slot, and then places the sample; a remove
// searches from the bottom up to the hit, through every entry on a miss, and then shifts
// the entries behind the hit down. A report runs on one shared restoring divider (one
// quotient bit a cycle, four divisions of 2*(16+log2 MAX_SAMPLES) bits) and one shared
// digit-by-digit square root (two radicand bits a cycle, two roots), then the median
// reads. The store is not cleared at reset; only entries below the count are ever
// read.
module sample_statistics_engine_core
	import sse_pkg::*;
#(
	parameter int MAX_SAMPLES = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         req_type,
	input  logic signed [15:0] sample_value,
	output logic               done,
	output logic [1:0]         status,
	output logic [8:0]         sample_count,
	output logic signed [15:0] mean_value,
	output logic [15:0]        std_deviation,
	output logic [15:0]        mean_error,
	output logic signed [15:0] median_value
);
	localparam int L  = $clog2(MAX_SAMPLES);
	localparam int AW = (L < 1) ? 1 : L;        // store address
	localparam int CW = L + 1;                  // count, holds MAX_SAMPLES
	localparam int SW = 16 + L;                 // running sum
	localparam int QW = 32 + L;                 // running sum of squares
	localparam int PW = 2 * SW;                 // product and dividend width
	localparam int RW = QW + (QW % 2);          // radicand, even width
	localparam int H  = RW / 2;                 // root width
	localparam int KW = $clog2(PW + 1);

	// sequencer states
	localparam logic [4:0] S_IDLE    = 5'd0;
	localparam logic [4:0] S_DISP    = 5'd1;
	localparam logic [4:0] S_ADD_RD  = 5'd2;
	localparam logic [4:0] S_ADD_CMP = 5'd3;
	localparam logic [4:0] S_ADD_PUT = 5'd4;
	localparam logic [4:0] S_REM_RD  = 5'd5;
	localparam logic [4:0] S_REM_CMP = 5'd6;
	localparam logic [4:0] S_SH_RD   = 5'd7;
	localparam logic [4:0] S_SH_WR   = 5'd8;
	localparam logic [4:0] S_MUL     = 5'd9;
	localparam logic [4:0] S_DIV_LD  = 5'd10;
	localparam logic [4:0] S_DIV     = 5'd11;
	localparam logic [4:0] S_DIV_END = 5'd12;
	localparam logic [4:0] S_SQ_LD   = 5'd13;
	localparam logic [4:0] S_SQ      = 5'd14;
	localparam logic [4:0] S_SQ_END  = 5'd15;
	localparam logic [4:0] S_MED_A   = 5'd16;
	localparam logic [4:0] S_MED_B   = 5'd17;
	localparam logic [4:0] S_MED_C   = 5'd18;

	logic [4:0]         state_q;
	logic [1:0]         req_q;
	logic signed [15:0] val_q;
	logic [CW-1:0]      cnt_q;
	logic [CW-1:0]      idx_q;
	logic signed [SW-1:0] sum_q;
	logic [QW-1:0]      sq_q;
	logic [PW-1:0]      prod_q;
	logic [1:0]         ph_q;

	// store
	logic signed [15:0] mem [MAX_SAMPLES];
	logic signed [15:0] rd_q;
	logic               we;
	logic [AW-1:0]      wa, ra;
	logic signed [15:0] wd;

	// divider
	logic [PW-1:0] dq_q;
	logic [CW-1:0] rq_q, dv_q;
	logic [KW-1:0] st_q;
	logic [CW:0]   dshift;
	logic          dge;

	// square root
	logic [RW-1:0] x_q;
	logic [H+1:0]  sr_q;
	logic [H-1:0]  root_q;
	logic [H+3:0]  scand, strial;
	logic          sge;

	// report intermediates
	logic [QW-1:0]      num_q, var_q, ve_q;
	logic signed [15:0] mean_q, a_q;
	logic [15:0]        sd_q;

	// result registers
	logic               done_q;
	logic [1:0]         status_q;
	logic signed [15:0] out_mean_q, out_med_q;
	logic [15:0]        out_sd_q, out_err_q;

	logic signed [SW-1:0] mul_op;
	logic signed [PW-1:0] mul_p;
	logic [CW-1:0]        cnt_m1;
	logic [CW+8:0]        cnt_ext;
	logic [PW-1:0]        sum_abs;
	logic [15:0]          qneg;
	logic signed [16:0]   med_sum;
	logic                 accept;

	assign accept = start && (state_q == S_IDLE);
	assign cnt_m1 = cnt_q - CW'(1);

	// one shared multiplier: v*v at accept, sum*sum for the report
	assign mul_op = (state_q == S_IDLE) ? SW'(sample_value) : sum_q;
	assign mul_p  = PW'(mul_op) * PW'(mul_op);

	assign sum_abs = sum_q[SW-1] ? (PW'(0) - PW'(sum_q)) : PW'(sum_q);
	assign qneg    = sum_q[SW-1] ? (16'd0 - dq_q[15:0]) : dq_q[15:0];
	assign med_sum = 17'(a_q) + 17'(rd_q);

	// divider step: shift one dividend bit into the partial remainder
	assign dshift = {rq_q, dq_q[PW-1]};
	assign dge    = dshift >= {1'b0, dv_q};

	// root step: bring down two radicand bits, try 4*root+1
	assign scand  = {sr_q, x_q[RW-1:RW-2]};
	assign strial = {2'b00, root_q, 2'b01};
	assign sge    = scand >= strial;

	// memory port control
	always_comb begin
		we = 1'b0;
		wa = idx_q[AW-1:0];
		wd = val_q;
		ra = idx_q[AW-1:0];
		case (state_q)
			S_DISP: begin
				we = (req_q == REQ_ADD) && (cnt_q == CW'(0));
				wa = '0;
			end
			S_ADD_CMP: begin
				we = 1'b1;
				wa = AW'(idx_q + CW'(1));
				wd = (rd_q > val_q) ? rd_q : val_q;
			end
			S_ADD_PUT: begin
				we = 1'b1;
				wa = '0;
			end
			S_SH_RD:  ra = AW'(idx_q + CW'(1));
			S_SH_WR: begin
				we = 1'b1;
				wd = rd_q;
			end
			S_MED_A:  ra = AW'(cnt_q >> 1);
			S_MED_B:  ra = AW'(cnt_m1 >> 1);
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_q <= mem[ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			sum_q    <= '0;
			sq_q     <= '0;
			done_q   <= 1'b0;
			status_q <= ST_OK;
			ph_q     <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						req_q   <= req_type;
						val_q   <= sample_value;
						prod_q  <= PW'(mul_p);
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					out_mean_q <= '0;
					out_sd_q   <= '0;
					out_err_q  <= '0;
					out_med_q  <= '0;
					status_q   <= ST_OK;
					idx_q      <= '0;
					ph_q       <= '0;
					case (req_q)
						REQ_ADD: begin
							if (cnt_q >= CW'(MAX_SAMPLES)) begin
								status_q <= ST_FULL;
								done_q   <= 1'b1;
								state_q  <= S_IDLE;
							end else if (cnt_q == CW'(0)) begin
								cnt_q   <= cnt_q + CW'(1);
								sum_q   <= sum_q + SW'(val_q);
								sq_q    <= sq_q + prod_q[QW-1:0];
								done_q  <= 1'b1;
								state_q <= S_IDLE;
							end else begin
								idx_q   <= cnt_m1;
								state_q <= S_ADD_RD;
							end
						end
						REQ_REMOVE: begin
							if (cnt_q == CW'(0)) begin
								status_q <= ST_NOT_FOUND;
								done_q   <= 1'b1;
								state_q  <= S_IDLE;
							end else begin
								state_q <= S_REM_RD;
							end
						end
						REQ_REPORT: begin
							if (cnt_q < CW'(2)) begin
								status_q <= ST_TOO_FEW;
								done_q   <= 1'b1;
								state_q  <= S_IDLE;
							end else begin
								state_q <= S_MUL;
							end
						end
						default: begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
					endcase
				end
				S_ADD_RD: state_q <= S_ADD_CMP;
				S_ADD_CMP: begin
					// entry moved up one slot, or the sample placed above it
					if (rd_q > val_q) begin
						if (idx_q == CW'(0)) begin
							state_q <= S_ADD_PUT;
						end else begin
							idx_q   <= idx_q - CW'(1);
							state_q <= S_ADD_RD;
						end
					end else begin
						cnt_q   <= cnt_q + CW'(1);
						sum_q   <= sum_q + SW'(val_q);
						sq_q    <= sq_q + prod_q[QW-1:0];
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_ADD_PUT: begin
					cnt_q   <= cnt_q + CW'(1);
					sum_q   <= sum_q + SW'(val_q);
					sq_q    <= sq_q + prod_q[QW-1:0];
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_REM_RD: state_q <= S_REM_CMP;
				S_REM_CMP: begin
					if (rd_q == val_q) begin
						if (idx_q == cnt_m1) begin
							cnt_q   <= cnt_m1;
							sum_q   <= sum_q - SW'(val_q);
							sq_q    <= sq_q - prod_q[QW-1:0];
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_SH_RD;
						end
					end else if (idx_q == cnt_m1) begin
						status_q <= ST_NOT_FOUND;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						idx_q   <= idx_q + CW'(1);
						state_q <= S_REM_RD;
					end
				end
				S_SH_RD: state_q <= S_SH_WR;
				S_SH_WR: begin
					if (idx_q + CW'(1) == cnt_m1) begin
						cnt_q   <= cnt_m1;
						sum_q   <= sum_q - SW'(val_q);
						sq_q    <= sq_q - prod_q[QW-1:0];
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						idx_q   <= idx_q + CW'(1);
						state_q <= S_SH_RD;
					end
				end
				S_MUL: begin
					prod_q  <= PW'(mul_p);
					state_q <= S_DIV_LD;
				end
				S_DIV_LD: begin
					// mean, sum^2/N, num/(N-1), var/N
					case (ph_q)
						2'd0: dq_q <= sum_abs;
						2'd1: dq_q <= prod_q;
						2'd2: dq_q <= PW'(num_q);
						default: dq_q <= PW'(var_q);
					endcase
					dv_q    <= (ph_q == 2'd2) ? cnt_m1 : cnt_q;
					rq_q    <= '0;
					st_q    <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					rq_q <= dge ? CW'(dshift - {1'b0, dv_q}) : dshift[CW-1:0];
					dq_q <= {dq_q[PW-2:0], dge};
					st_q <= st_q + KW'(1);
					if (st_q == KW'(PW - 1)) begin
						state_q <= S_DIV_END;
					end
				end
				S_DIV_END: begin
					case (ph_q)
						2'd0: mean_q <= qneg;
						2'd1: num_q  <= sq_q - dq_q[QW-1:0];
						2'd2: var_q  <= dq_q[QW-1:0];
						default: ve_q <= dq_q[QW-1:0];
					endcase
					if (ph_q == 2'd3) begin
						ph_q    <= '0;
						state_q <= S_SQ_LD;
					end else begin
						ph_q    <= ph_q + 2'd1;
						state_q <= S_DIV_LD;
					end
				end
				S_SQ_LD: begin
					x_q     <= (ph_q == 2'd0) ? RW'(var_q) : RW'(ve_q);
					sr_q    <= '0;
					root_q  <= '0;
					st_q    <= '0;
					state_q <= S_SQ;
				end
				S_SQ: begin
					sr_q   <= sge ? (H+2)'(scand - strial) : scand[H+1:0];
					root_q <= {root_q[H-2:0], sge};
					x_q    <= {x_q[RW-3:0], 2'b00};
					st_q   <= st_q + KW'(1);
					if (st_q == KW'(H - 1)) begin
						state_q <= S_SQ_END;
					end
				end
				S_SQ_END: begin
					if (ph_q == 2'd0) begin
						sd_q    <= root_q[15:0];
						ph_q    <= 2'd1;
						state_q <= S_SQ_LD;
					end else begin
						out_err_q <= root_q[15:0];
						state_q   <= S_MED_A;
					end
				end
				S_MED_A: state_q <= S_MED_B;
				S_MED_B: begin
					a_q     <= rd_q;
					state_q <= S_MED_C;
				end
				S_MED_C: begin
					out_med_q  <= med_sum[16:1];
					out_mean_q <= mean_q;
					out_sd_q   <= sd_q;
					done_q     <= 1'b1;
					state_q    <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign cnt_ext       = {9'd0, cnt_q};
	assign busy          = (state_q != S_IDLE);
	assign done          = done_q;
	assign status        = status_q;
	assign sample_count  = cnt_ext[8:0];
	assign mean_value    = out_mean_q;
	assign std_deviation = out_sd_q;
	assign mean_error    = out_err_q;
	assign median_value  = out_med_q;

`ifndef SYNTHESIS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result shown while busy");
	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_SAMPLES)) else $error("count above store depth");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accepted item did not start");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("result without an item");
	a_cnt_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(!busy && !done) |=> (cnt_q == $past(cnt_q) || done))
		else $error("count moved while idle");
`endif
endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// Testbench for sample_statistics_engine_core: random and directed add, remove and report
// items checked against a predictor of the sorted store. Depends on sse_pkg and the core.
module tb;
	import sse_pkg::*;

	localparam int DEPTH      = 256;
	localparam int IDLE_LIMIT = 20000;
	localparam int N_ITEMS    = 1350;

	typedef struct {
		logic [1:0]         status;
		logic [8:0]         count;
		logic signed [15:0] mean;
		logic [15:0]        sigma;
		logic [15:0]        sem;
		logic signed [15:0] median;
	} stats_t;

	// Scoreboard: holds its own sorted copy of the store and the queue of expected results
	class stats_board;
		shortint   store[$];
		longint    sum;
		longint    sumsq;
		stats_t    pending[$];
		int        errors;

		function new();
			sum = 0;
			sumsq = 0;
			errors = 0;
		endfunction

		function longint root(longint x);
			longint r;
			r = 0;
			for (int b = 31; b >= 0; b--) begin
				if ((r | (64'd1 << b)) * (r | (64'd1 << b)) <= x)
					r = r | (64'd1 << b);
			end
			return r;
		endfunction

		// Update the store for an accepted item and queue what the core must answer
		function void note_item(logic [1:0] req, shortint val);
			stats_t  e;
			int      pos;
			longint  n, vr, a, b;
			e = '{ST_OK, 9'd0, 16'sd0, 16'd0, 16'd0, 16'sd0};
			case (req)
				REQ_ADD: begin
					if (store.size() >= DEPTH)
						e.status = ST_FULL;
					else begin
						pos = 0;
						while (pos < store.size() && store[pos] <= val)
							pos++;
						store.insert(pos, val);
						sum += val;
						sumsq += longint'(val) * val;
					end
				end
				REQ_REMOVE: begin
					pos = -1;
					foreach (store[i])
						if (pos < 0 && store[i] == val)
							pos = i;
					if (pos < 0)
						e.status = ST_NOT_FOUND;
					else begin
						store.delete(pos);
						sum -= val;
						sumsq -= longint'(val) * val;
					end
				end
				REQ_REPORT: begin
					if (store.size() < 2)
						e.status = ST_TOO_FEW;
					else begin
						n = store.size();
						e.mean = 16'(sum / n);
						vr = (sumsq - (sum * sum) / n) / (n - 1);
						e.sigma = 16'(root(vr));
						e.sem = 16'(root(vr / n));
						a = store[n / 2];
						b = store[(n - 1) / 2];
						e.median = 16'((a + b) >>> 1);
					end
				end
				default: ;
			endcase
			e.count = 9'(store.size());
			pending = {pending, e};
		endfunction

		function void check_result(stats_t got);
			stats_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result status=%0d count=%0d", $time, got.status,
					got.count);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.status !== e.status) begin
				$display("%0t: status exp %0d got %0d", $time, e.status, got.status);
				errors++;
			end
			if (got.count !== e.count) begin
				$display("%0t: count exp %0d got %0d", $time, e.count, got.count);
				errors++;
			end
			if (got.mean !== e.mean) begin
				$display("%0t: mean exp %0d got %0d", $time, e.mean, got.mean);
				errors++;
			end
			if (got.sigma !== e.sigma) begin
				$display("%0t: sigma exp %0d got %0d", $time, e.sigma, got.sigma);
				errors++;
			end
			if (got.sem !== e.sem) begin
				$display("%0t: mean error exp %0d got %0d", $time, e.sem, got.sem);
				errors++;
			end
			if (got.median !== e.median) begin
				$display("%0t: median exp %0d got %0d", $time, e.median, got.median);
				errors++;
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [1:0]         req_type;
	logic signed [15:0] sample_value;
	logic               done;
	logic [1:0]         status;
	logic [8:0]         sample_count;
	logic signed [15:0] mean_value;
	logic [15:0]        std_deviation;
	logic [15:0]        mean_error;
	logic signed [15:0] median_value;

	stats_board board;
	int         idle_cycles;

	sample_statistics_engine_core #(.MAX_SAMPLES(DEPTH)) u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req_type(req_type), .sample_value(sample_value), .done(done),
		.status(status), .sample_count(sample_count), .mean_value(mean_value),
		.std_deviation(std_deviation), .mean_error(mean_error),
		.median_value(median_value)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Result capture, item acceptance and the stall watchdog all sample before the edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				board.check_result('{status, sample_count, mean_value, std_deviation,
					mean_error, median_value});
			if ((start && !busy) || done)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: watchdog expired", $time);
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	// Present one item after a random gap and hold it until the core takes it
	task automatic send_item(logic [1:0] req, logic signed [15:0] val);
		int gap;
		gap = $urandom_range(0, 19);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req_type <= req;
		sample_value <= val;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		board.note_item(req, val);
	endtask

	function automatic logic signed [15:0] pick_value();
		case ($urandom_range(0, 5))
			0: return -16'sd32768;
			1: return 16'sd32767;
			2: return 16'($urandom_range(0, 8)) - 16'sd4;
			default: return 16'($urandom);
		endcase
	endfunction

	// Remove a held sample most of the time so removes actually hit
	function automatic logic signed [15:0] held_or_random();
		if (board.store.size() > 0 && $urandom_range(0, 4) != 0)
			return board.store[$urandom_range(0, board.store.size() - 1)];
		return pick_value();
	endfunction

	task automatic random_item();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			send_item(REQ_ADD, pick_value());
		else if (r < 70)
			send_item(REQ_REMOVE, held_or_random());
		else if (r < 95)
			send_item(REQ_REPORT, 16'($urandom));
		else
			send_item(REQ_IGNORED, 16'($urandom));
	endtask

	initial begin
		int sent;
		board = new();
		idle_cycles = 0;
		arst_n <= 1'b0;
		start <= 1'b0;
		req_type <= REQ_ADD;
		sample_value <= 16'sd0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty store, single sample, extremes, duplicates, misses, unused code
		send_item(REQ_REPORT, 16'sd0);
		send_item(REQ_REMOVE, 16'sd7);
		send_item(REQ_ADD, -16'sd32768);
		send_item(REQ_REPORT, 16'sd0);
		send_item(REQ_ADD, 16'sd32767);
		send_item(REQ_REPORT, 16'sd0);
		send_item(REQ_ADD, 16'sd0);
		send_item(REQ_ADD, 16'sd0);
		send_item(REQ_REPORT, 16'sd0);
		send_item(REQ_REMOVE, 16'sd0);
		send_item(REQ_REMOVE, 16'sd5);
		send_item(REQ_IGNORED, 16'sd1);
		send_item(REQ_ADD, -16'sd1);
		send_item(REQ_ADD, -16'sd32768);
		send_item(REQ_REPORT, 16'sd0);
		send_item(REQ_REMOVE, 16'sd32767);
		send_item(REQ_REPORT, -16'sd1);
		sent = 17;

		// Hold off until the core has answered everything
		start <= 1'b0;
		while (board.pending.size() != 0)
			@(posedge clk);

		// Fill to the top, overflow it, then drain with reports in between
		while (board.store.size() < DEPTH) begin
			send_item(REQ_ADD, pick_value());
			sent++;
			if ($urandom_range(0, 15) == 0) begin
				send_item(REQ_REPORT, 16'sd0);
				sent++;
			end
		end
		repeat (3) send_item(REQ_ADD, pick_value());
		send_item(REQ_REPORT, 16'sd0);
		sent += 4;
		while (board.store.size() > 0) begin
			send_item(REQ_REMOVE, held_or_random());
			sent++;
			if ($urandom_range(0, 15) == 0) begin
				send_item(REQ_REPORT, 16'sd0);
				sent++;
			end
		end

		while (sent < N_ITEMS) begin
			random_item();
			sent++;
		end
		start <= 1'b0;

		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (board.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
